FILE: rtl/core/dafc_pkg.sv
package dafc_pkg;

    // Fade timing
    localparam int ACTIVATE_FADE_MS = 100;
    localparam int MAX_FADE_MS      = 1000;
    localparam int MS_PER_LEVEL     = 20;

    // Field and register widths
    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 24;
    localparam int FADE_W     = 11;
    localparam int PCT_W      = 7;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Shared divider: quotient always fits in a level
    localparam int QUO_W      = LEVEL_W;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int DIVIDEND_W = 22;
    localparam int DIVISOR_W  = 14;
    localparam int PROD_W     = LEVEL_W + FADE_W;
    localparam int LEN_W      = LEVEL_W + 7;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FOCUS      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREV_BEGIN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PREV_VALUE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PREV_END   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_APPLY      = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PCT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INACTIVE_PCT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_AVAIL  = 2'd3;

    // Constants
    localparam logic [LEVEL_W-1:0] LEVEL_OPAQUE   = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR    = 8'd10;
    localparam logic [PCT_W-1:0]   PCT_FULL       = 7'd100;
    localparam logic [PCT_W-1:0]   ACTIVE_PCT_MIN = 7'd30;
    localparam logic [PCT_W-1:0]   FACTOR_PCT_MIN = 7'd10;
    localparam logic [TIME_W-1:0]  DELAY_MIN      = 24'd20;
    localparam logic [TIME_W-1:0]  DELAY_MAX      = 24'd10000000;
    localparam logic [TIME_W-1:0]  TIME_SAT       = {TIME_W{1'b1}};
    localparam logic [DIVISOR_W-1:0] PCT_SCALE    = 14'd100;
    localparam logic [DIVISOR_W-1:0] PCT2_SCALE   = 14'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_MUL,
        ST_DIV,
        ST_APPLY
    } state_t;

    function automatic logic [PCT_W-1:0] pct_clamp(
        input logic [PCT_W-1:0] v,
        input logic [PCT_W-1:0] lo,
        input logic [PCT_W-1:0] hi
    );
        logic [PCT_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/delayed_alpha_fade_controller.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------------------
// input    | s_valid / s_ready           | s_kind, s_focused, s_visible, s_preview_pct
// result   | m_valid / m_ready           | m_alpha, m_layered, m_fading
// config   | cfg_wr_en (no wait)         | cfg_wr_idx, cfg_wr_data
//
// One beat in gives one beat out. An accepted item passes the time, multiply, divide
// and apply states in order, and s_ready stays low until it is back in idle. The shared
// restoring divider retires one quotient bit per cycle.
// aresetn is synchronous, active low. A result waiting on m_ready does not block
// the next input beat; that beat stalls only in its final step until m_ready.
module delayed_alpha_fade_controller
    import dafc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic                  s_focused,
    input  logic                  s_visible,
    input  logic [PCT_W-1:0]      s_preview_pct,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LEVEL_W-1:0]    m_alpha,
    output logic                  m_layered,
    output logic                  m_fading
);

    // Configuration
    logic [PCT_W-1:0]  active_pct_reg;
    logic [PCT_W-1:0]  factor_pct_reg;
    logic [TIME_W-1:0] delay_reg;
    logic              layer_avail_reg;

    // Controller state
    state_t             state_reg, state_next;
    logic [LEVEL_W-1:0] cur_reg, cur_next;
    logic [LEVEL_W-1:0] start_reg, start_next;
    logic [LEVEL_W-1:0] target_reg, target_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;
    logic [FADE_W-1:0]  fade_reg, fade_next;
    logic               fade_run_reg, fade_run_next;
    logic               layer_on_reg, layer_on_next;
    logic               preview_reg, preview_next;
    logic               last_focus_reg, last_focus_next;

    // Item latch
    logic [KIND_W-1:0] kind_reg;
    logic              focused_reg;
    logic              visible_reg;
    logic [PCT_W-1:0]  pct_reg;

    // Divider and time
    logic [TIME_W-1:0]     e_reg;
    logic                  use_target_reg;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVIDEND_W-1:0] dsh_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [STEP_W-1:0]     step_reg;

    // Output register
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] m_alpha_reg;
    logic               m_layered_reg;
    logic               m_fading_reg;

    logic in_beat;
    logic out_free;
    logic commit;
    logic tick_live;
    logic focus_sel;

    logic [TIME_W-1:0]     el_inc;
    logic [TIME_W-1:0]     e_calc;
    logic [FADE_W-1:0]     e_short;
    logic                  use_target;
    logic [PROD_W-1:0]     prod_start;
    logic [PROD_W-1:0]     prod_target;
    logic [PCT_W-1:0]      prev_pct;
    logic [DIVIDEND_W-1:0] af_prod;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;

    // Handshake and step control
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        in_beat  = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        commit   = (state_reg == ST_APPLY) && out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) begin
                state_next = ST_TIME;
            end
            ST_TIME:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (step_reg == STEP_W'(QUO_W - 1)) begin
                state_next = ST_APPLY;
            end
            ST_APPLY: if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes, saturated into range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_pct_reg  <= PCT_FULL;
            factor_pct_reg  <= PCT_FULL;
            delay_reg       <= '0;
            layer_avail_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                REG_ACTIVE_PCT:
                    active_pct_reg <= pct_clamp(cfg_wr_data[PCT_W-1:0], ACTIVE_PCT_MIN,
                                                PCT_FULL);
                REG_INACTIVE_PCT:
                    factor_pct_reg <= pct_clamp(cfg_wr_data[PCT_W-1:0], FACTOR_PCT_MIN,
                                                PCT_FULL);
                REG_DELAY:
                    delay_reg <= (cfg_wr_data > DELAY_MAX) ? DELAY_MAX
                                                           : cfg_wr_data[TIME_W-1:0];
                REG_LAYER_AVAIL:
                    layer_avail_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Which focus state picks the level for this beat
    always_comb begin
        unique case (kind_reg)
            KIND_FOCUS:    focus_sel = focused_reg;
            KIND_PREV_END: focus_sel = last_focus_reg;
            KIND_APPLY:    focus_sel = visible_reg ? focused_reg : 1'b1;
            default:       focus_sel = 1'b1;
        endcase
    end

    // Tick time: saturating elapsed count and moving time past the wait
    always_comb begin
        tick_live = (kind_reg == KIND_TICK) && fade_run_reg;
        el_inc    = (elapsed_reg == TIME_SAT) ? elapsed_reg : elapsed_reg + 1'b1;
        e_calc    = (el_inc >= wait_reg) ? el_inc - wait_reg : '0;
    end

    // Dividend and divisor for this beat
    always_comb begin
        e_short     = e_reg[FADE_W-1:0];
        use_target  = (fade_reg == '0) || (e_reg >= TIME_W'(fade_reg));
        prod_start  = PROD_W'(start_reg) * PROD_W'(fade_reg - e_short);
        prod_target = PROD_W'(target_reg) * PROD_W'(e_short);
        prev_pct    = pct_clamp(pct_reg, ACTIVE_PCT_MIN, PCT_FULL);
        af_prod     = DIVIDEND_W'(active_pct_reg) * DIVIDEND_W'(factor_pct_reg);
        if (kind_reg == KIND_TICK) begin
            if (use_target) begin
                dividend = '0;
                divisor  = DIVISOR_W'(1);
            end else begin
                dividend = DIVIDEND_W'(prod_start) + DIVIDEND_W'(prod_target);
                divisor  = DIVISOR_W'(fade_reg);
            end
        end else if (kind_reg == KIND_PREV_VALUE) begin
            // times 255 as times 256 minus one
            dividend = (DIVIDEND_W'(prev_pct) << LEVEL_W) - DIVIDEND_W'(prev_pct);
            divisor  = PCT_SCALE;
        end else if (focus_sel) begin
            dividend = (DIVIDEND_W'(active_pct_reg) << LEVEL_W)
                       - DIVIDEND_W'(active_pct_reg);
            divisor  = PCT_SCALE;
        end else begin
            dividend = (af_prod << LEVEL_W) - af_prod;
            divisor  = PCT2_SCALE;
        end
    end

    // Item latch, time stage and shared restoring divider
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            kind_reg    <= s_kind;
            focused_reg <= s_focused;
            visible_reg <= s_visible;
            pct_reg     <= s_preview_pct;
        end
        unique case (state_reg)
            ST_TIME: begin
                e_reg <= e_calc;
            end
            ST_MUL: begin
                use_target_reg <= use_target;
                rem_reg        <= dividend;
                dsh_reg        <= DIVIDEND_W'(divisor) << (QUO_W - 1);
                step_reg       <= '0;
            end
            ST_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Item update from the divider quotient
    always_comb begin
        logic [LEVEL_W-1:0] lvl_focus;
        logic [LEVEL_W-1:0] lvl_tick;
        logic [LEVEL_W-1:0] cur_eff;
        logic [LEVEL_W-1:0] chg_level;
        logic [LEVEL_W-1:0] chg_cur;
        logic [LEVEL_W-1:0] diff;
        logic [LEN_W-1:0]   len;
        logic               do_chg;
        logic               chg_delayed;

        cur_next        = cur_reg;
        start_next      = start_reg;
        target_next     = target_reg;
        elapsed_next    = elapsed_reg;
        wait_next       = wait_reg;
        fade_next       = fade_reg;
        fade_run_next   = fade_run_reg;
        layer_on_next   = layer_on_reg;
        preview_next    = preview_reg;
        last_focus_next = last_focus_reg;

        do_chg      = 1'b0;
        chg_delayed = 1'b0;
        chg_level   = quo_reg;
        chg_cur     = cur_reg;

        lvl_focus = (!focus_sel && (quo_reg < LEVEL_FLOOR)) ? LEVEL_FLOOR : quo_reg;
        lvl_tick  = use_target_reg ? target_reg : quo_reg;
        cur_eff   = layer_on_reg ? cur_reg : LEVEL_OPAQUE;

        unique case (kind_reg)
            KIND_TICK: begin
                if (fade_run_reg) begin
                    cur_next = lvl_tick;
                    if (lvl_tick == target_reg) begin
                        fade_run_next = 1'b0;
                    end
                end
            end
            KIND_FOCUS: begin
                if (layer_on_reg) begin
                    last_focus_next = focused_reg;
                    do_chg          = !preview_reg;
                    chg_level       = lvl_focus;
                    chg_delayed     = !focused_reg;
                end
            end
            KIND_PREV_BEGIN: begin
                if (layer_avail_reg && !preview_reg) begin
                    preview_next = 1'b1;
                end
            end
            KIND_PREV_VALUE: begin
                if (preview_reg && (quo_reg != cur_reg)) begin
                    layer_on_next = 1'b1;
                    cur_next      = cur_eff;
                    do_chg        = 1'b1;
                    chg_cur       = cur_eff;
                end
            end
            KIND_PREV_END: begin
                if (preview_reg) begin
                    preview_next = 1'b0;
                    if (layer_on_reg) begin
                        do_chg      = 1'b1;
                        chg_level   = lvl_focus;
                        chg_delayed = !last_focus_reg;
                    end
                end
            end
            KIND_APPLY: begin
                if (!layer_avail_reg) begin
                    layer_on_next = 1'b0;
                end else if ((active_pct_reg == PCT_FULL) && (factor_pct_reg == PCT_FULL)) begin
                    // layering not needed: back to opaque, fade left alone
                    if (layer_on_reg) begin
                        layer_on_next = 1'b0;
                        cur_next      = LEVEL_OPAQUE;
                    end
                end else begin
                    layer_on_next = 1'b1;
                    cur_next      = cur_eff;
                    if (visible_reg) begin
                        last_focus_next = focused_reg;
                        do_chg          = !preview_reg;
                        chg_level       = lvl_focus;
                        chg_delayed     = !focused_reg;
                        chg_cur         = cur_eff;
                    end else begin
                        // hidden: jump to the focused level, no fade
                        cur_next      = quo_reg;
                        fade_run_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // Start a fade toward chg_level, or stop the fade when already at that level
        diff = (chg_cur > chg_level) ? chg_cur - chg_level : chg_level - chg_cur;
        len  = LEN_W'(diff) * LEN_W'(MS_PER_LEVEL);
        if (len > LEN_W'(MAX_FADE_MS)) begin
            len = LEN_W'(MAX_FADE_MS);
        end
        if (do_chg) begin
            if (chg_level == chg_cur) begin
                fade_run_next = 1'b0;
            end else begin
                target_next   = chg_level;
                start_next    = chg_cur;
                elapsed_next  = '0;
                wait_next     = (!chg_delayed || (delay_reg <= DELAY_MIN)) ? '0 : delay_reg;
                fade_run_next = 1'b1;
                if (!chg_delayed || (delay_reg == '0)) begin
                    fade_next = FADE_W'(ACTIVATE_FADE_MS);
                end else begin
                    fade_next = len[FADE_W-1:0];
                end
            end
        end
    end

    // Controller state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= LEVEL_OPAQUE;
            start_reg      <= LEVEL_OPAQUE;
            target_reg     <= LEVEL_OPAQUE;
            elapsed_reg    <= '0;
            wait_reg       <= '0;
            fade_reg       <= FADE_W'(ACTIVATE_FADE_MS);
            fade_run_reg   <= 1'b0;
            layer_on_reg   <= 1'b0;
            preview_reg    <= 1'b0;
            last_focus_reg <= 1'b1;
        end else if (commit) begin
            cur_reg        <= cur_next;
            start_reg      <= start_next;
            target_reg     <= target_next;
            elapsed_reg    <= elapsed_next;
            wait_reg       <= wait_next;
            fade_reg       <= fade_next;
            fade_run_reg   <= fade_run_next;
            layer_on_reg   <= layer_on_next;
            preview_reg    <= preview_next;
            last_focus_reg <= last_focus_next;
        end else if ((state_reg == ST_TIME) && tick_live) begin
            elapsed_reg <= el_inc;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (commit) begin
            m_alpha_reg   <= cur_next;
            m_layered_reg <= layer_on_next;
            m_fading_reg  <= fade_run_next;
        end
    end

    // Result port
    always_comb begin
        m_valid   = m_valid_reg;
        m_alpha   = m_alpha_reg;
        m_layered = m_layered_reg;
        m_fading  = m_fading_reg;
    end

endmodule
